// File: rtl/core/sit_pkg.sv
`timescale 1ns / 1ps

package sit_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int FILL_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 2;

  // item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_TAKE   = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_TAKE
  } sit_state_t;

  // controller to datapath
  typedef struct packed {
    logic do_insert;   // apply the accepted insert, load its acknowledge
    logic take_start;  // latch the clamped count, rewind the read index
    logic emit;        // load the next stored entry into the result register
  } sit_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic take_empty;  // the item on the input would read nothing
    logic take_last;   // the entry under the read index is the final one
  } sit_sts_t;

endpackage

// File: rtl/core/sit_in_if.sv
`timescale 1ns / 1ps

interface sit_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [sit_pkg::VALUE_W-1:0]  value;
  logic [sit_pkg::COUNT_W-1:0]  take_count;

  modport source (output valid, output kind, output value, output take_count, input ready);
  modport sink   (input valid, input kind, input value, input take_count, output ready);
endinterface

// File: rtl/core/sit_out_if.sv
`timescale 1ns / 1ps

interface sit_out_if;
  logic                          valid;
  logic                          ready;
  logic [sit_pkg::STATUS_W-1:0]  status;
  logic [sit_pkg::VALUE_W-1:0]   entry;
  logic                          last;

  modport source (output valid, output status, output entry, output last, input ready);
  modport sink   (input valid, input status, input entry, input last, output ready);
endinterface

// File: rtl/core/sit_ctrl.sv
`timescale 1ns / 1ps

module sit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output sit_pkg::sit_cmd_t cmd,
  input  sit_pkg::sit_sts_t sts
);

  sit_pkg::sit_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                slot_free;
  logic                in_acc;

  assign slot_free = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sit_pkg::S_IDLE: begin
        if (in_acc && in_kind == sit_pkg::KIND_TAKE && !sts.take_empty) begin
          state_nxt = sit_pkg::S_TAKE;
        end
      end
      sit_pkg::S_TAKE: begin
        if (slot_free && sts.take_last) begin
          state_nxt = sit_pkg::S_IDLE;
        end
      end
      default: state_nxt = sit_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      sit_pkg::S_IDLE: begin
        in_ready = slot_free;
        if (in_acc) begin
          if (in_kind == sit_pkg::KIND_INSERT) begin
            cmd.do_insert = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.take_start = 1'b1;
            // an empty take answers at once
            if (sts.take_empty) begin
              out_valid_nxt = 1'b1;
            end
          end
        end
      end
      sit_pkg::S_TAKE: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sit_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/sit_dp.sv
`timescale 1ns / 1ps

module sit_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sit_pkg::sit_cmd_t             cmd,
  output sit_pkg::sit_sts_t             sts,
  input  logic [sit_pkg::VALUE_W-1:0]   in_value,
  input  logic [sit_pkg::COUNT_W-1:0]   in_take_count,
  output logic [sit_pkg::STATUS_W-1:0]  out_status,
  output logic [sit_pkg::VALUE_W-1:0]   out_entry,
  output logic                          out_last
);

  logic [sit_pkg::VALUE_W-1:0]  tbl_r [sit_pkg::DEPTH];
  logic [sit_pkg::FILL_W-1:0]   fill_r;
  logic [sit_pkg::FILL_W-1:0]   n_r;
  logic [sit_pkg::IDX_W-1:0]    idx_r;
  logic [sit_pkg::STATUS_W-1:0] status_r;
  logic [sit_pkg::VALUE_W-1:0]  entry_r;
  logic                         last_r;

  logic                         full;
  logic                         ins_en;
  logic [sit_pkg::DEPTH-1:0]    gt;
  logic [sit_pkg::DEPTH-1:0]    at_or_after;
  logic [sit_pkg::FILL_W-1:0]   n_in;

  assign full   = fill_r == sit_pkg::FILL_W'(sit_pkg::DEPTH);
  assign ins_en = cmd.do_insert && !full;

  // clamp the requested count to the fill level
  assign n_in = (in_take_count < sit_pkg::COUNT_W'(fill_r))
              ? in_take_count[sit_pkg::FILL_W-1:0] : fill_r;

  assign sts.take_empty = n_in == '0;
  assign sts.take_last  = (sit_pkg::FILL_W'(idx_r) + sit_pkg::FILL_W'(1)) == n_r;

  // mark every slot at or after the insertion point; the table is sorted,
  // so the marks form one contiguous run ending at the fill level
  always_comb begin
    for (int i = 0; i < sit_pkg::DEPTH; i++) begin
      gt[i] = (sit_pkg::FILL_W'(i) < fill_r) && (tbl_r[i] > in_value);
      at_or_after[i] = (sit_pkg::FILL_W'(i) < fill_r) ? gt[i]
                     : (sit_pkg::FILL_W'(i) == fill_r);
    end
  end

  for (genvar g = 0; g < sit_pkg::DEPTH; g++) begin : g_slot
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (ins_en && at_or_after[0]) begin
          tbl_r[0] <= in_value;
        end
      end
    end else begin : g_body
      // take the new value at the insertion point, else shift up by one
      always_ff @(posedge clk) begin
        if (ins_en && at_or_after[g]) begin
          tbl_r[g] <= at_or_after[g-1] ? tbl_r[g-1] : in_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ins_en) begin
      fill_r <= fill_r + sit_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_start) begin
      n_r   <= n_in;
      idx_r <= '0;
    end else if (cmd.emit) begin
      idx_r <= idx_r + sit_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      status_r <= full ? sit_pkg::ST_FULL : sit_pkg::ST_INSERTED;
      entry_r  <= '0;
      last_r   <= 1'b1;
    end else if (cmd.take_start) begin
      status_r <= sit_pkg::ST_NONE;
      entry_r  <= '0;
      last_r   <= 1'b1;
    end else if (cmd.emit) begin
      status_r <= sit_pkg::ST_ENTRY;
      entry_r  <= tbl_r[idx_r];
      last_r   <= sts.take_last;
    end
  end

  assign out_status = status_r;
  assign out_entry  = entry_r;
  assign out_last   = last_r;

endmodule

// File: rtl/core/sorted_insert_table.sv
// Sorted insert table: keeps up to DEPTH unsigned 32-bit values in ascending order.
// Input channel in_ch carries one transaction per item: kind 0 inserts value,
// kind 1 reads out the first take_count stored values (clamped to the fill level).
// Result channel out_ch returns status, entry and last for every result.
// An insert answers with one result (inserted, or full and dropped) that sits in
// the result register the cycle after acceptance, the compare and shift across all
// slots happening in the cycle of acceptance.
// A take of n entries (up to DEPTH) enters the take state, which then loads them
// into the result register one per cycle while the receiver drains them, read out by
// the controller through a single read index; no new item is taken meanwhile. A take
// of zero entries answers like an insert. Equal values go after those already stored.
// in_ch.ready is high only while no take is being read out and the result register
// is empty or being drained in the same cycle.
// When the receiver stalls, the result register holds its contents and the block
// waits; no new item is taken until the waiting result has been drained.
// Reset (rst_n low, synchronous) empties the table and drops any pending result;
// no clearing pass is needed.
`timescale 1ns / 1ps

module sorted_insert_table (
  input  logic      clk,
  input  logic      rst_n,
  sit_in_if.sink    in_ch,
  sit_out_if.source out_ch
);

  sit_pkg::sit_cmd_t cmd;
  sit_pkg::sit_sts_t sts;

  sit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  sit_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_ch.value),
    .in_take_count (in_ch.take_count),
    .out_status    (out_ch.status),
    .out_entry     (out_ch.entry),
    .out_last      (out_ch.last)
  );

endmodule

// File: rtl/core/sit_chk.sv
`timescale 1ns / 1ps

module sit_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_kind,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sit_pkg::STATUS_W-1:0]  out_status,
  input logic [sit_pkg::VALUE_W-1:0]   out_entry,
  input logic                          out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) && $stable(out_entry) && $stable(out_last))
    else $error("stalled result changed");

  // input is only taken when the result register can be refilled
  a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input ready while result register blocked");

  // an insert is acknowledged in the next cycle with a single final result
  a_insert_ack: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == sit_pkg::KIND_INSERT |=>
      out_valid && out_last &&
      (out_status == sit_pkg::ST_INSERTED || out_status == sit_pkg::ST_FULL))
    else $error("insert not acknowledged");

  // only entry results carry data, and every other result is final
  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sit_pkg::ST_ENTRY |-> out_entry == '0 && out_last)
    else $error("non-entry result carries data or is not final");

endmodule

bind sorted_insert_table sit_chk u_sit_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_kind    (in_ch.kind),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_entry  (out_ch.entry),
  .out_last   (out_ch.last)
);

// File: tb/tb_sorted_insert_table.sv
`timescale 1ns / 1ps

module tb_sorted_insert_table;
  import sit_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 205;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  entry;
    logic                last;
  } table_result_t;

  // Shadow of the table contents plus the queue of answers still owed by the block.
  class sorted_table_tracker;
    logic [VALUE_W-1:0] stored [DEPTH];
    int unsigned        fill;
    table_result_t      pending [$];
    int unsigned        mismatches;
    int unsigned        n_stored, n_dropped, n_takes, n_entries, n_results;

    function new();
      fill       = 0;
      mismatches = 0;
      n_stored   = 0;
      n_dropped  = 0;
      n_takes    = 0;
      n_entries  = 0;
      n_results  = 0;
    endfunction

    function void note_item(logic kind, logic [VALUE_W-1:0] value,
                            logic [COUNT_W-1:0] count);
      int unsigned pos, n, i;
      if (kind == KIND_INSERT) begin
        if (fill == DEPTH) begin
          pending.push_back('{ST_FULL, '0, 1'b1});
          n_dropped++;
        end else begin
          // equal values go behind the ones already held
          pos = 0;
          while (pos < fill && stored[pos] <= value) pos++;
          for (i = fill; i > pos; i--) stored[i] = stored[i-1];
          stored[pos] = value;
          fill++;
          pending.push_back('{ST_INSERTED, '0, 1'b1});
          n_stored++;
        end
      end else begin
        n_takes++;
        n = (count < fill) ? count : fill;
        if (n == 0) begin
          pending.push_back('{ST_NONE, '0, 1'b1});
        end else begin
          for (i = 0; i < n; i++) pending.push_back('{ST_ENTRY, stored[i], i + 1 == n});
        end
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] entry,
                               logic last);
      table_result_t want;
      n_results++;
      if (status == ST_ENTRY) n_entries++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result: status %0d entry %h last %0d",
                   $time, status, entry, last);
        return;
      end
      want = pending.pop_front();
      if (status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status);
      end
      if (entry !== want.entry) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: entry mismatch: expected %h, actual %h", $time, want.entry, entry);
      end
      if (last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: last mismatch: expected %0d, actual %0d", $time, want.last, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sit_in_if  in_ch ();
  sit_out_if out_ch ();

  sorted_table_tracker table_track = new();

  logic [15:0] drain_pattern;
  int unsigned pattern_age;
  int unsigned idle_cycles;

  sorted_insert_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic push_item(input logic kind, input logic [VALUE_W-1:0] value,
                           input logic [COUNT_W-1:0] count);
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= kind;
    in_ch.value      <= value;
    in_ch.take_count <= count;
    do @(posedge clk); while (!in_ch.ready);
    table_track.note_item(kind, value, count);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // result side: check every transaction, stall on a rotating pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready  <= 1'b0;
      drain_pattern <= 16'hffff;
      pattern_age   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        table_track.check_result(out_ch.status, out_ch.entry, out_ch.last);
      out_ch.ready <= drain_pattern[0];
      if (pattern_age == 63) begin
        pattern_age <= 0;
        case ($urandom_range(0, 3))
          0:       drain_pattern <= 16'hffff;
          1:       drain_pattern <= 16'($urandom & $urandom) | 16'h0001;
          default: drain_pattern <= 16'($urandom) | 16'h0001;
        endcase
      end else begin
        pattern_age   <= pattern_age + 1;
        drain_pattern <= {drain_pattern[0], drain_pattern[15:1]};
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned         burst;
    logic                kind;
    logic [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]  count;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_INSERT;
    in_ch.value      <= '0;
    in_ch.take_count <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, both the zero count and the largest count
    push_item(KIND_TAKE, 32'($urandom), '0);
    push_item(KIND_TAKE, 32'($urandom), 16'hffff);
    push_item(KIND_INSERT, 32'hffff_ffff, 16'($urandom));
    push_item(KIND_INSERT, 32'h0000_0000, 16'($urandom));
    pause_sender(3);
    push_item(KIND_INSERT, 32'h8000_0000, 16'($urandom));
    push_item(KIND_INSERT, 32'h8000_0000, 16'($urandom));
    push_item(KIND_TAKE, 32'($urandom), '0);
    push_item(KIND_TAKE, 32'($urandom), 16'd1);
    push_item(KIND_TAKE, 32'($urandom), 16'hffff);
    push_item(KIND_INSERT, 32'h7fff_ffff, 16'($urandom));
    push_item(KIND_INSERT, 32'hffff_ffff, 16'($urandom));
    push_item(KIND_INSERT, 32'h0000_0000, 16'($urandom));
    push_item(KIND_TAKE, 32'($urandom), 16'd7);
    pause_sender(5);
    // fill every remaining slot, then try one insert more on the full table
    repeat (DEPTH - 7) push_item(KIND_INSERT, 32'($urandom), 16'($urandom));
    push_item(KIND_INSERT, 32'hffff_ffff, 16'($urandom));
    push_item(KIND_TAKE, 32'($urandom), 16'(DEPTH));
    push_item(KIND_TAKE, 32'($urandom), 16'(DEPTH + 1));

    for (int unsigned sent = 0; sent < RANDOM_ITEMS; sent += burst) begin
      burst = $urandom_range(1, 12);
      for (int unsigned k = 0; k < burst; k++) begin
        kind = $urandom_range(0, 1) ? KIND_TAKE : KIND_INSERT;
        case ($urandom_range(0, 9))
          0:       value = '0;
          1:       value = '1;
          default: value = 32'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0:       count = '0;
          1:       count = '1;
          2, 3:    count = 16'($urandom);
          default: count = 16'($urandom_range(1, DEPTH));
        endcase
        push_item(kind, value, count);
      end
      // no gap now and then, so back-to-back runs occur too
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 15));
    end
    in_ch.valid <= 1'b0;

    while (table_track.pending.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);

    $display("Items: %0d stored, %0d dropped on a full table, %0d takes",
             table_track.n_stored, table_track.n_dropped, table_track.n_takes);
    $display("Results checked: %0d, of which %0d were entries read out",
             table_track.n_results, table_track.n_entries);
    if (table_track.mismatches == 0 && table_track.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
